>>> src/rde_pkg.sv
package rde_pkg;

    // Ring depth; any value from 2 to 65536 works.
    localparam int DEPTH = 1024;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        OP_CLEAR   = 3'd0,
        OP_LOAD    = 3'd1,
        OP_REVERSE = 3'd2,
        OP_DELETE  = 3'd3,
        OP_READ    = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_GIVEN     = 3'd1,
        ST_EMPTY_ERR = 3'd2,
        ST_IGNORED   = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef struct packed {
        logic [2:0]  operation;
        logic [30:0] value;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [30:0] element;
        logic        last;
    } t_result;

endpackage

>>> src/reversible_deque_engine.sv
// Latency: a command transferred at one rising edge has its result on o_result,
// marked by o_done, during the following cycle. Throughput: one command per cycle;
// busy stays low, since each command touches at most one ring entry through a
// single memory port and the pointers update at the transfer edge.
// Reset (i_rst_n low at a rising edge) empties the list and clears both flags;
// the ring contents are left as they are. The receiver cannot stall results.
module reversible_deque_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  rde_pkg::t_item  i_item,
    output logic            o_done,
    output rde_pkg::t_result o_result
);
    import rde_pkg::*;

    // Ring storage: one synchronous memory, one write and one read port with
    // registered read data.
    logic [30:0]   r_ring [DEPTH];
    logic [30:0]   r_rdata;

    // List bookkeeping. The head is the physical slot of the oldest element;
    // the reversed flag only changes which end a removal takes from.
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic          r_reversed, n_reversed;
    logic          r_error, n_error;

    // Result register. When r_take is set the element comes from the memory
    // read that was launched at the transfer edge.
    logic          r_done;
    logic          r_take, n_take;
    logic [2:0]    r_status, n_status;
    logic          r_last, n_last;

    logic          accept;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [AW:0]   sum_tail;
    logic [AW:0]   sum_back;
    logic [AW-1:0] tail_slot;
    logic [AW-1:0] back_slot;
    logic [AW-1:0] head_next;
    logic          list_empty;
    logic          list_full;

    // The engine never holds off a command.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign list_empty = (r_count == '0);
    assign list_full  = (r_count >= CW'(DEPTH));

    // Slot arithmetic modulo DEPTH: each sum stays below twice the depth, so
    // one compare and subtract brings it back into range.
    always_comb begin
        sum_tail = (AW+1)'(r_head) + (AW+1)'(r_count);
        sum_back = sum_tail - (AW+1)'(1);
        if (sum_tail >= (AW+1)'(DEPTH)) begin
            tail_slot = AW'(sum_tail - (AW+1)'(DEPTH));
        end else begin
            tail_slot = AW'(sum_tail);
        end
        if (sum_back >= (AW+1)'(DEPTH)) begin
            back_slot = AW'(sum_back - (AW+1)'(DEPTH));
        end else begin
            back_slot = AW'(sum_back);
        end
        if (r_head == AW'(DEPTH - 1)) begin
            head_next = '0;
        end else begin
            head_next = r_head + AW'(1);
        end
    end

    // Command decode. A removal takes from the back while reversed and from
    // the head otherwise; delete and read share that path.
    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        n_reversed = r_reversed;
        n_error    = r_error;
        n_take     = 1'b0;
        n_status   = ST_DONE;
        n_last     = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_raddr  = r_reversed ? back_slot : r_head;

        unique case (i_item.operation) inside
            OP_CLEAR: begin
                n_head     = '0;
                n_count    = '0;
                n_reversed = 1'b0;
                n_error    = 1'b0;
            end
            OP_LOAD: begin
                // Loads still append after an error; only a full ring drops them.
                if (list_full) begin
                    n_status = ST_FULL;
                end else begin
                    mem_we  = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            OP_REVERSE: begin
                if (r_error) begin
                    n_status = ST_IGNORED;
                end else begin
                    n_reversed = !r_reversed;
                end
            end
            OP_DELETE, OP_READ: begin
                if (r_error) begin
                    n_status = ST_IGNORED;
                end else if (list_empty) begin
                    if (i_item.operation == OP_DELETE) begin
                        n_status = ST_EMPTY_ERR;
                        n_error  = 1'b1;
                    end else begin
                        n_status = ST_EMPTY;
                    end
                end else begin
                    n_count = r_count - CW'(1);
                    if (!r_reversed) begin
                        n_head = head_next;
                    end
                    if (i_item.operation == OP_READ) begin
                        mem_re   = 1'b1;
                        n_take   = 1'b1;
                        n_status = ST_GIVEN;
                        n_last   = (r_count == CW'(1));
                    end
                end
            end
            default: begin
                // Unused operation codes change nothing and report done.
            end
        endcase
    end

    // A write and a read never fall on the same edge, since each edge carries
    // at most one command, so no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (accept && mem_we) begin
            r_ring[tail_slot] <= i_item.value;
        end
        if (accept && mem_re) begin
            r_rdata <= r_ring[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_count    <= '0;
            r_reversed <= 1'b0;
            r_error    <= 1'b0;
            r_done     <= 1'b0;
            r_take     <= 1'b0;
        end else begin
            r_done <= accept;
            if (accept) begin
                r_head     <= n_head;
                r_count    <= n_count;
                r_reversed <= n_reversed;
                r_error    <= n_error;
                r_take     <= n_take;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_last   <= n_last;
        end
    end

    assign o_done           = r_done;
    assign o_result.status  = r_status;
    assign o_result.element = r_take ? r_rdata : '0;
    assign o_result.last    = r_last;

    // Every transfer yields exactly one result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_done)
        else $error("command transfer without a result in the next cycle");

    // The element count never exceeds the ring depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count beyond ring depth");

    // An element is only given when the list held one.
    a_given_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (n_status == ST_GIVEN) |-> r_count != '0)
        else $error("element given from an empty list");

    // Once the error flag is set, reads are ignored.
    a_error_blocks_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_error && (i_item.operation == OP_READ)
        |=> o_result.status == ST_IGNORED)
        else $error("read not ignored after an error");

endmodule
